// File: rtl/rlpm_pkg.sv
package rlpm_pkg;

    localparam int unsigned ADDR_W = 32;
    localparam int unsigned SLOT_W = 4;
    localparam int unsigned PORT_W = 2;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef struct packed {
        logic wr;
        logic load;
        logic rd;
        logic emit;
    } t_dp_cmd;

endpackage

// File: rtl/route_longest_prefix_match.sv
// IPv4 longest-prefix-match routing table.
// Command channel: an item is taken at a clock edge with start high and
// busy low. i_func selects a slot write or an address lookup.
// A write stores the route fields at i_slot_index in the same cycle and
// gives no result; busy stays low, so writes can be issued every cycle
// outside a lookup. Writes to a slot at or above ENTRIES are dropped.
// A lookup raises busy and walks the table one slot per cycle through a
// single read port of the route memory, then passes a flush state and a
// done state. The result appears on the o_ ports with o_valid high for
// one cycle; busy drops in that same cycle, so a new item can be taken
// while the result is shown. A new lookup is not taken before the last
// one has given its result.
// The largest mask wins, the lowest slot wins a tie, and a zero mask
// matches every address. No match gives o_hit low and zero fields.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (synchronous, active low) invalidates all slots and aborts any
// lookup in progress without a result.
module route_longest_prefix_match #(
    parameter int unsigned ENTRIES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_func,
    input  logic [rlpm_pkg::SLOT_W-1:0] i_slot_index,
    input  logic                        i_slot_valid,
    input  logic [rlpm_pkg::ADDR_W-1:0] i_route_dest,
    input  logic [rlpm_pkg::ADDR_W-1:0] i_route_mask,
    input  logic [rlpm_pkg::ADDR_W-1:0] i_route_gateway,
    input  logic [rlpm_pkg::PORT_W-1:0] i_route_port,
    input  logic [rlpm_pkg::ADDR_W-1:0] i_lookup_addr,
    output logic                        o_valid,
    output logic                        o_hit,
    output logic [rlpm_pkg::SLOT_W-1:0] o_match_slot,
    output logic [rlpm_pkg::ADDR_W-1:0] o_next_hop,
    output logic [rlpm_pkg::PORT_W-1:0] o_out_port,
    output logic [rlpm_pkg::ADDR_W-1:0] o_match_mask
);

    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    rlpm_pkg::t_dp_cmd cmd;
    logic [IW-1:0]     rd_idx;

    rlpm_ctrl #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_func   (i_func),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_cmd    (cmd),
        .o_rd_idx (rd_idx)
    );

    rlpm_datapath #(
        .ENTRIES (ENTRIES),
        .IW      (IW)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_rd_idx        (rd_idx),
        .i_slot_index    (i_slot_index),
        .i_slot_valid    (i_slot_valid),
        .i_route_dest    (i_route_dest),
        .i_route_mask    (i_route_mask),
        .i_route_gateway (i_route_gateway),
        .i_route_port    (i_route_port),
        .i_lookup_addr   (i_lookup_addr),
        .o_hit           (o_hit),
        .o_match_slot    (o_match_slot),
        .o_next_hop      (o_next_hop),
        .o_out_port      (o_out_port),
        .o_match_mask    (o_match_mask)
    );

endmodule

// File: rtl/rlpm_ctrl.sv
module rlpm_ctrl #(
    parameter int unsigned ENTRIES = 16,
    parameter int unsigned IW      = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               i_func,
    output logic               busy,
    output logic               o_valid,
    output rlpm_pkg::t_dp_cmd  o_cmd,
    output logic [IW-1:0]      o_rd_idx
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_DONE
    } t_state;

    t_state        r_state, n_state;
    logic [IW-1:0] r_cnt, n_cnt;
    logic          r_valid;
    logic          accept;
    logic          last;

    assign accept = start && (r_state == S_IDLE);
    assign last   = (r_cnt == IW'(ENTRIES - 1));

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (accept && (i_func == rlpm_pkg::FUNC_LOOKUP)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (last) begin
                    n_state = S_FLUSH;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FLUSH: n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= (r_state == S_DONE);
        end
    end

    always_comb begin
        o_cmd.wr   = accept && (i_func == rlpm_pkg::FUNC_WRITE);
        o_cmd.load = accept && (i_func == rlpm_pkg::FUNC_LOOKUP);
        o_cmd.rd   = (r_state == S_SCAN);
        o_cmd.emit = (r_state == S_DONE);
    end

    assign o_rd_idx = r_cnt;
    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;

endmodule

// File: rtl/rlpm_datapath.sv
module rlpm_datapath #(
    parameter int unsigned ENTRIES = 16,
    parameter int unsigned IW      = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rlpm_pkg::t_dp_cmd               i_cmd,
    input  logic [IW-1:0]                   i_rd_idx,
    input  logic [rlpm_pkg::SLOT_W-1:0]     i_slot_index,
    input  logic                            i_slot_valid,
    input  logic [rlpm_pkg::ADDR_W-1:0]     i_route_dest,
    input  logic [rlpm_pkg::ADDR_W-1:0]     i_route_mask,
    input  logic [rlpm_pkg::ADDR_W-1:0]     i_route_gateway,
    input  logic [rlpm_pkg::PORT_W-1:0]     i_route_port,
    input  logic [rlpm_pkg::ADDR_W-1:0]     i_lookup_addr,
    output logic                            o_hit,
    output logic [rlpm_pkg::SLOT_W-1:0]     o_match_slot,
    output logic [rlpm_pkg::ADDR_W-1:0]     o_next_hop,
    output logic [rlpm_pkg::PORT_W-1:0]     o_out_port,
    output logic [rlpm_pkg::ADDR_W-1:0]     o_match_mask
);

    logic [rlpm_pkg::ADDR_W-1:0] mem_dest [ENTRIES];
    logic [rlpm_pkg::ADDR_W-1:0] mem_mask [ENTRIES];
    logic [rlpm_pkg::ADDR_W-1:0] mem_gw   [ENTRIES];
    logic [rlpm_pkg::PORT_W-1:0] mem_port [ENTRIES];
    logic                        r_slot_valid [ENTRIES];

    logic [IW-1:0]               wr_addr;
    logic                        wr_en;

    logic [rlpm_pkg::ADDR_W-1:0] r_addr;
    logic                        r_cmp;
    logic [IW-1:0]               r_cmp_idx;
    logic                        r_cmp_valid;
    logic [rlpm_pkg::ADDR_W-1:0] r_rd_dest;
    logic [rlpm_pkg::ADDR_W-1:0] r_rd_mask;
    logic [rlpm_pkg::ADDR_W-1:0] r_rd_gw;
    logic [rlpm_pkg::PORT_W-1:0] r_rd_port;

    logic                        r_found;
    logic [IW-1:0]               r_best_idx;
    logic [rlpm_pkg::ADDR_W-1:0] r_best_mask;
    logic [rlpm_pkg::ADDR_W-1:0] r_best_gw;
    logic [rlpm_pkg::PORT_W-1:0] r_best_port;

    logic                        match;
    logic                        take;

    assign wr_addr = IW'(i_slot_index);
    assign wr_en   = i_cmd.wr && ({5'b0, i_slot_index} < 9'(ENTRIES));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_dest[wr_addr] <= i_route_dest;
            mem_mask[wr_addr] <= i_route_mask;
            mem_gw[wr_addr]   <= i_route_gateway;
            mem_port[wr_addr] <= i_route_port;
        end
        if (i_cmd.rd) begin
            r_rd_dest <= mem_dest[i_rd_idx];
            r_rd_mask <= mem_mask[i_rd_idx];
            r_rd_gw   <= mem_gw[i_rd_idx];
            r_rd_port <= mem_port[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_slot_valid[i] <= 1'b0;
            end
        end else if (wr_en) begin
            r_slot_valid[wr_addr] <= i_slot_valid;
        end
    end

    assign match = r_cmp && r_cmp_valid
                   && ((r_addr & r_rd_mask) == (r_rd_dest & r_rd_mask));
    assign take  = match && (!r_found || (r_rd_mask > r_best_mask));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp   <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_cmp <= i_cmd.rd;
            if (i_cmd.load) begin
                r_found <= 1'b0;
            end else if (take) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr <= i_lookup_addr;
        end
        if (i_cmd.rd) begin
            r_cmp_idx   <= i_rd_idx;
            r_cmp_valid <= r_slot_valid[i_rd_idx];
        end
        if (take) begin
            r_best_idx  <= r_cmp_idx;
            r_best_mask <= r_rd_mask;
            r_best_gw   <= r_rd_gw;
            r_best_port <= r_rd_port;
        end
        if (i_cmd.emit) begin
            o_hit        <= r_found;
            o_match_slot <= r_found ? rlpm_pkg::SLOT_W'(r_best_idx) : '0;
            o_next_hop   <= r_found ? r_best_gw : '0;
            o_out_port   <= r_found ? r_best_port : '0;
            o_match_mask <= r_found ? r_best_mask : '0;
        end
    end

endmodule

// File: sim/route_lpm_checker.sv
module route_lpm_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic                        func,
    input  logic [rlpm_pkg::SLOT_W-1:0] slot_index,
    input  logic                        slot_valid,
    input  logic [rlpm_pkg::ADDR_W-1:0] route_dest,
    input  logic [rlpm_pkg::ADDR_W-1:0] route_mask,
    input  logic [rlpm_pkg::ADDR_W-1:0] route_gateway,
    input  logic [rlpm_pkg::PORT_W-1:0] route_port,
    input  logic [rlpm_pkg::ADDR_W-1:0] lookup_addr,
    input  logic                        o_valid,
    input  logic                        o_hit,
    input  logic [rlpm_pkg::SLOT_W-1:0] o_match_slot,
    input  logic [rlpm_pkg::ADDR_W-1:0] o_next_hop,
    input  logic [rlpm_pkg::PORT_W-1:0] o_out_port,
    input  logic [rlpm_pkg::ADDR_W-1:0] o_match_mask,
    output int                          fail_count,
    output int                          pending
);

    localparam int unsigned TABLE_SLOTS = 16;

    typedef struct packed {
        logic                        hit;
        logic [rlpm_pkg::SLOT_W-1:0] slot;
        logic [rlpm_pkg::ADDR_W-1:0] next_hop;
        logic [rlpm_pkg::PORT_W-1:0] port;
        logic [rlpm_pkg::ADDR_W-1:0] mask;
    } t_route_answer;

    logic                        tbl_live [TABLE_SLOTS];
    logic [rlpm_pkg::ADDR_W-1:0] tbl_dest [TABLE_SLOTS];
    logic [rlpm_pkg::ADDR_W-1:0] tbl_mask [TABLE_SLOTS];
    logic [rlpm_pkg::ADDR_W-1:0] tbl_gw   [TABLE_SLOTS];
    logic [rlpm_pkg::PORT_W-1:0] tbl_port [TABLE_SLOTS];

    t_route_answer pending_answers[$];

    initial begin
        fail_count = 0;
        pending    = 0;
        for (int k = 0; k < TABLE_SLOTS; k++) begin
            tbl_live[k] = 1'b0;
            tbl_dest[k] = '0;
            tbl_mask[k] = '0;
            tbl_gw[k]   = '0;
            tbl_port[k] = '0;
        end
    end

    task automatic report_mismatch(string what, logic [rlpm_pkg::ADDR_W-1:0] got,
                                   logic [rlpm_pkg::ADDR_W-1:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    // largest mask wins, lowest slot wins a tie, first match always taken
    function automatic t_route_answer lookup_route(logic [rlpm_pkg::ADDR_W-1:0] addr);
        t_route_answer ans;
        logic          found;
        ans   = '0;
        found = 1'b0;
        for (int k = 0; k < TABLE_SLOTS; k++) begin
            if (tbl_live[k] && ((addr & tbl_mask[k]) == (tbl_dest[k] & tbl_mask[k])) &&
                (!found || tbl_mask[k] > ans.mask)) begin
                found        = 1'b1;
                ans.hit      = 1'b1;
                ans.slot     = rlpm_pkg::SLOT_W'(k);
                ans.next_hop = tbl_gw[k];
                ans.port     = tbl_port[k];
                ans.mask     = tbl_mask[k];
            end
        end
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_route_answer want;
        if (!i_rst_n) begin
            pending_answers.delete();
            for (int k = 0; k < TABLE_SLOTS; k++) tbl_live[k] = 1'b0;
        end else begin
            if (o_valid) begin
                if (pending_answers.size() == 0) begin
                    report_mismatch("result with no lookup pending", '0, '0);
                end else begin
                    want = pending_answers.pop_front();
                    if (o_hit !== want.hit)
                        report_mismatch("hit", rlpm_pkg::ADDR_W'(o_hit),
                                        rlpm_pkg::ADDR_W'(want.hit));
                    if (o_match_slot !== want.slot)
                        report_mismatch("match_slot", rlpm_pkg::ADDR_W'(o_match_slot),
                                        rlpm_pkg::ADDR_W'(want.slot));
                    if (o_next_hop !== want.next_hop)
                        report_mismatch("next_hop", o_next_hop, want.next_hop);
                    if (o_out_port !== want.port)
                        report_mismatch("out_port", rlpm_pkg::ADDR_W'(o_out_port),
                                        rlpm_pkg::ADDR_W'(want.port));
                    if (o_match_mask !== want.mask)
                        report_mismatch("match_mask", o_match_mask, want.mask);
                end
            end
            if (start && !busy) begin
                if (func == rlpm_pkg::FUNC_LOOKUP) begin
                    pending_answers.push_back(lookup_route(lookup_addr));
                end else if (slot_index < TABLE_SLOTS) begin
                    tbl_live[slot_index] = slot_valid;
                    tbl_dest[slot_index] = route_dest;
                    tbl_mask[slot_index] = route_mask;
                    tbl_gw[slot_index]   = route_gateway;
                    tbl_port[slot_index] = route_port;
                end
            end
        end
        pending <= pending_answers.size();
    end

endmodule

// File: sim/tb_top.sv
module tb_top;

    localparam int RANDOM_ITEMS = 2000;
    localparam int NET_COUNT    = 6;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        start         = 1'b0;
    logic                        func          = rlpm_pkg::FUNC_WRITE;
    logic [rlpm_pkg::SLOT_W-1:0] slot_index    = '0;
    logic                        slot_valid    = 1'b0;
    logic [rlpm_pkg::ADDR_W-1:0] route_dest    = '0;
    logic [rlpm_pkg::ADDR_W-1:0] route_mask    = '0;
    logic [rlpm_pkg::ADDR_W-1:0] route_gateway = '0;
    logic [rlpm_pkg::PORT_W-1:0] route_port    = '0;
    logic [rlpm_pkg::ADDR_W-1:0] lookup_addr   = '0;

    logic                        busy;
    logic                        o_valid;
    logic                        o_hit;
    logic [rlpm_pkg::SLOT_W-1:0] o_match_slot;
    logic [rlpm_pkg::ADDR_W-1:0] o_next_hop;
    logic [rlpm_pkg::PORT_W-1:0] o_out_port;
    logic [rlpm_pkg::ADDR_W-1:0] o_match_mask;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int burst_left  = 1;

    logic [rlpm_pkg::ADDR_W-1:0] nets [NET_COUNT];

    always #4 i_clk = ~i_clk;

    route_longest_prefix_match dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (func),
        .i_slot_index    (slot_index),
        .i_slot_valid    (slot_valid),
        .i_route_dest    (route_dest),
        .i_route_mask    (route_mask),
        .i_route_gateway (route_gateway),
        .i_route_port    (route_port),
        .i_lookup_addr   (lookup_addr),
        .o_valid         (o_valid),
        .o_hit           (o_hit),
        .o_match_slot    (o_match_slot),
        .o_next_hop      (o_next_hop),
        .o_out_port      (o_out_port),
        .o_match_mask    (o_match_mask)
    );

    route_lpm_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .slot_index    (slot_index),
        .slot_valid    (slot_valid),
        .route_dest    (route_dest),
        .route_mask    (route_mask),
        .route_gateway (route_gateway),
        .route_port    (route_port),
        .lookup_addr   (lookup_addr),
        .o_valid       (o_valid),
        .o_hit         (o_hit),
        .o_match_slot  (o_match_slot),
        .o_next_hop    (o_next_hop),
        .o_out_port    (o_out_port),
        .o_match_mask  (o_match_mask),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [rlpm_pkg::ADDR_W-1:0] prefix_mask(int unsigned len);
        return (len == 0) ? '0 : ({rlpm_pkg::ADDR_W{1'b1}} << (rlpm_pkg::ADDR_W - len));
    endfunction

    // called at a rising edge; returns at the edge that took the item, or after a pause if the burst ended
    task automatic issue(logic f, logic [rlpm_pkg::SLOT_W-1:0] idx, logic v,
                         logic [rlpm_pkg::ADDR_W-1:0] dest,
                         logic [rlpm_pkg::ADDR_W-1:0] mask,
                         logic [rlpm_pkg::ADDR_W-1:0] gw,
                         logic [rlpm_pkg::PORT_W-1:0] port,
                         logic [rlpm_pkg::ADDR_W-1:0] addr);
        logic free;
        start         <= 1'b1;
        func          <= f;
        slot_index    <= idx;
        slot_valid    <= v;
        route_dest    <= dest;
        route_mask    <= mask;
        route_gateway <= gw;
        route_port    <= port;
        lookup_addr   <= addr;
        do begin
            @(negedge i_clk);
            free = !busy;
            @(posedge i_clk);
        end while (!free);
        burst_left--;
        if (burst_left <= 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
    endtask

    task automatic write_route(logic [rlpm_pkg::SLOT_W-1:0] idx, logic v,
                               logic [rlpm_pkg::ADDR_W-1:0] dest,
                               logic [rlpm_pkg::ADDR_W-1:0] mask,
                               logic [rlpm_pkg::ADDR_W-1:0] gw,
                               logic [rlpm_pkg::PORT_W-1:0] port);
        issue(rlpm_pkg::FUNC_WRITE, idx, v, dest, mask, gw, port, $urandom);
    endtask

    task automatic lookup(logic [rlpm_pkg::ADDR_W-1:0] addr);
        issue(rlpm_pkg::FUNC_LOOKUP, rlpm_pkg::SLOT_W'($urandom), 1'($urandom), $urandom,
              $urandom, $urandom, rlpm_pkg::PORT_W'($urandom), addr);
    endtask

    initial begin
        int unsigned pick;
        int unsigned plen;
        logic [rlpm_pkg::ADDR_W-1:0] net;
        logic [rlpm_pkg::ADDR_W-1:0] mask;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table
        lookup(32'h0000_0000);
        lookup(32'hFFFF_FFFF);
        // default route matches anything
        write_route(4'd0, 1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0A00_0001, 2'd0);
        lookup(32'hC0A8_0105);
        // nested prefixes /8 /16 /24 /32
        write_route(4'd1, 1'b1, 32'h0A00_0000, prefix_mask(8), 32'h0A00_00FE, 2'd1);
        write_route(4'd2, 1'b1, 32'h0A01_0000, prefix_mask(16), 32'h0A01_00FE, 2'd2);
        write_route(4'd3, 1'b1, 32'h0A01_0200, prefix_mask(24), 32'h0A01_02FE, 2'd3);
        write_route(4'd15, 1'b1, 32'h0A01_0203, prefix_mask(32), 32'hFFFF_FFFF, 2'd3);
        lookup(32'h0A01_0203);
        lookup(32'h0A01_0204);
        lookup(32'h0A01_0909);
        lookup(32'h0AC8_0001);
        // equal masks: lower slot wins
        write_route(4'd4, 1'b1, 32'h0A01_FFFF, prefix_mask(16), 32'h1234_5678, 2'd1);
        lookup(32'h0A01_0909);
        // invalidated slot drops out
        write_route(4'd2, 1'b0, 32'h0A01_0000, prefix_mask(16), 32'h0A01_00FE, 2'd2);
        lookup(32'h0A01_0909);
        // all-ones host route replaces the default
        write_route(4'd0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 2'd0);
        lookup(32'hFFFF_FFFF);
        lookup(32'h0000_0000);
        // non-contiguous mask
        write_route(4'd5, 1'b1, 32'hAB00_CD00, 32'hFF00_FF00, 32'h5555_AAAA, 2'd2);
        lookup(32'hABFF_CDFF);
        lookup(32'hAB00_CE00);

        net = $urandom;
        for (int k = 0; k < NET_COUNT; k++)
            nets[k] = (k < 4) ? (net ^ ($urandom >> (8 * k))) : $urandom;

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            net  = nets[$urandom_range(0, NET_COUNT - 1)];
            plen = $urandom_range(0, 32);
            mask = ($urandom_range(0, 7) == 0) ? $urandom : prefix_mask(plen);
            if (pick < 30) begin
                write_route(rlpm_pkg::SLOT_W'($urandom), ($urandom_range(0, 7) != 0),
                            net ^ ($urandom & ~mask), mask, $urandom,
                            rlpm_pkg::PORT_W'($urandom));
            end else if (pick < 35) begin
                write_route(rlpm_pkg::SLOT_W'($urandom), 1'($urandom), $urandom, $urandom,
                            $urandom, rlpm_pkg::PORT_W'($urandom));
            end else if (pick < 85) begin
                lookup(net ^ ($urandom & ~prefix_mask($urandom_range(0, 32))));
            end else begin
                lookup($urandom);
            end
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
